// ===== hdl/i2ces_pkg.sv =====
package i2ces_pkg;

  localparam int unsigned AddrW         = 17;
  localparam int unsigned CountW        = 16;
  localparam int unsigned ByteW         = 8;
  localparam int unsigned CfgIdxW       = 3;
  localparam int unsigned MaxResults    = 3;
  localparam int unsigned ResCntW       = 2;
  localparam int unsigned PageBytesDef  = 256;

  typedef enum logic [2:0] {
    OP_NONE, OP_START, OP_STOP, OP_SEND, OP_RECV, OP_ACK, OP_NOACK
  } bus_op_e;

  typedef enum logic [1:0] {
    ST_BUSY, ST_WANT, ST_DONE, ST_FAIL
  } status_e;

  typedef enum logic [1:0] {
    FN_WRITE, FN_READ, FN_PAYLOAD, FN_REPLY
  } func_e;

  localparam logic [1:0] KindUpdate   = 2'd0;
  localparam logic [1:0] KindInternal = 2'd1;

  localparam logic [CfgIdxW-1:0] CfgIntLo  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgIntHi  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgUpdLo  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgUpdHi  = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgFlash  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRetry  = 3'd5;

  localparam logic [ByteW-1:0] IntLoRst  = 8'ha0;
  localparam logic [ByteW-1:0] IntHiRst  = 8'ha2;
  localparam logic [ByteW-1:0] UpdLoRst  = 8'ha8;
  localparam logic [ByteW-1:0] UpdHiRst  = 8'haa;
  localparam logic [ByteW-1:0] FlashRst  = 8'ha6;
  localparam logic [ByteW-1:0] RetryRst  = 8'hff;

  typedef struct packed {
    func_e              func;
    logic [AddrW-1:0]   start_address;
    logic [CountW-1:0]  byte_count;
    logic [1:0]         memory_kind;
    logic [ByteW-1:0]   payload_byte;
    logic               ack_bit;
    logic [ByteW-1:0]   received_byte;
  } item_t;

  typedef struct packed {
    bus_op_e            op;
    logic [ByteW-1:0]   tx;
    logic               prot;
    logic               rv;
    logic [ByteW-1:0]   rd;
    status_e            st;
  } result_t;

  typedef struct packed {
    logic [ByteW-1:0] int_lo;
    logic [ByteW-1:0] int_hi;
    logic [ByteW-1:0] upd_lo;
    logic [ByteW-1:0] upd_hi;
    logic [ByteW-1:0] flash;
    logic [ByteW-1:0] retry;
  } cfg_t;

  function automatic result_t mk_res(bus_op_e op, logic [ByteW-1:0] tx, logic prot,
                                     logic rv, logic [ByteW-1:0] rd, status_e st);
    result_t r;
    r.op   = op;
    r.tx   = tx;
    r.prot = prot;
    r.rv   = rv;
    r.rd   = rd;
    r.st   = st;
    return r;
  endfunction

endpackage

// ===== hdl/i2ces_if.sv =====
interface i2ces_in_if;
  import i2ces_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [AddrW-1:0]   start_address;
  logic [CountW-1:0]  byte_count;
  logic [1:0]         memory_kind;
  logic [ByteW-1:0]   payload_byte;
  logic               ack_bit;
  logic [ByteW-1:0]   received_byte;

  modport source (output valid, func, start_address, byte_count, memory_kind,
                  payload_byte, ack_bit, received_byte, input ready);
  modport sink   (input valid, func, start_address, byte_count, memory_kind,
                  payload_byte, ack_bit, received_byte, output ready);
endinterface

interface i2ces_out_if;
  import i2ces_pkg::*;
  logic             valid;
  logic             ready;
  logic [2:0]       bus_op;
  logic [ByteW-1:0] tx_byte;
  logic             protect_level;
  logic             read_valid;
  logic [ByteW-1:0] read_data;
  logic [1:0]       status;
  logic             last;

  modport source (output valid, bus_op, tx_byte, protect_level, read_valid, read_data,
                  status, last, input ready);
  modport sink   (input valid, bus_op, tx_byte, protect_level, read_valid, read_data,
                  status, last, output ready);
endinterface

interface i2ces_cfg_if;
  import i2ces_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/i2ces_engine.sv =====
module i2ces_engine #(
  parameter int unsigned PageBytes = i2ces_pkg::PageBytesDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  i2ces_pkg::cfg_t     cfg_i,
  input  i2ces_pkg::item_t    item_i,
  input  logic                take_i,
  output i2ces_pkg::result_t  res_o [i2ces_pkg::MaxResults],
  output logic [i2ces_pkg::ResCntW-1:0] res_cnt_o
);
  import i2ces_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_W_POLL, PH_W_ADRH, PH_W_ADRL, PH_W_WANT, PH_W_DATA,
    PH_R_POLL, PH_R_ADRH, PH_R_ADRL, PH_R_DEVRD, PH_R_RECV
  } phase_e;

  // page offset of the current address by reciprocal multiplication
  localparam int unsigned PageW  = $clog2(PageBytes);
  localparam int unsigned Shift  = AddrW + PageW + 1;
  localparam int unsigned RecipW = AddrW + 2;
  localparam int unsigned ProdW  = AddrW + RecipW;
  localparam logic [RecipW-1:0] Recip =
    RecipW'(((64'd1 << Shift) + 64'(PageBytes) - 64'd1) / 64'(PageBytes));

  phase_e              ph_q, ph_d;
  logic [AddrW-1:0]    cur_q, cur_d;
  logic [CountW-1:0]   done_q, done_d;
  logic [CountW-1:0]   total_q, total_d;
  logic [ByteW-1:0]    dev_q, dev_d;
  logic [ByteW-1:0]    poll_q, poll_d;
  logic                prot_q, prot_d;
  logic [ProdW-1:0]    prod_q;

  logic [AddrW-1:0]    cur_inc, quot, page_off;
  logic [CountW-1:0]   done_inc;
  logic [ByteW-1:0]    poll_inc, wdev;
  logic                page_end;

  // cur_q is always stable long enough for prod_q to follow it before a data reply looks at it
  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(cur_q) * ProdW'(Recip);
  end

  assign quot     = AddrW'(prod_q >> Shift);
  assign page_off = cur_q - AddrW'(quot * AddrW'(PageBytes));
  assign page_end = (cur_q == '1) || (page_off == AddrW'(PageBytes - 1));

  assign cur_inc  = cur_q + AddrW'(1);
  assign done_inc = done_q + CountW'(1);
  assign poll_inc = poll_q + ByteW'(1);
  assign wdev     = cur_inc[AddrW-1] ? cfg_i.int_hi : cfg_i.int_lo;

  always_comb begin
    ph_d      = ph_q;
    cur_d     = cur_q;
    done_d    = done_q;
    total_d   = total_q;
    dev_d     = dev_q;
    poll_d    = poll_q;
    prot_d    = prot_q;
    res_cnt_o = '0;
    for (int i = 0; i < MaxResults; i++) begin
      res_o[i] = mk_res(OP_NONE, '0, 1'b0, 1'b0, '0, ST_BUSY);
    end

    unique case (item_i.func)
      FN_WRITE: begin
        if (ph_q == PH_IDLE) begin
          cur_d   = item_i.start_address;
          total_d = item_i.byte_count;
          done_d  = '0;
          if (item_i.byte_count == '0) begin
            res_o[0]  = mk_res(OP_NONE, '0, prot_q, 1'b0, '0, ST_DONE);
            res_cnt_o = 2'd1;
          end else begin
            prot_d    = 1'b0;
            dev_d     = item_i.start_address[AddrW-1] ? cfg_i.int_hi : cfg_i.int_lo;
            res_o[0]  = mk_res(OP_START, '0, 1'b0, 1'b0, '0, ST_BUSY);
            res_o[1]  = mk_res(OP_SEND, dev_d, 1'b0, 1'b0, '0, ST_BUSY);
            res_cnt_o = 2'd2;
            ph_d      = PH_W_POLL;
          end
        end
      end
      FN_READ: begin
        if (ph_q == PH_IDLE) begin
          cur_d   = item_i.start_address;
          total_d = item_i.byte_count;
          done_d  = '0;
          poll_d  = '0;
          if (item_i.memory_kind == KindUpdate) begin
            dev_d = item_i.start_address[AddrW-1] ? cfg_i.upd_hi : cfg_i.upd_lo;
          end else if (item_i.memory_kind == KindInternal) begin
            dev_d = item_i.start_address[AddrW-1] ? cfg_i.int_hi : cfg_i.int_lo;
          end else begin
            dev_d = cfg_i.flash;
          end
          res_o[0]  = mk_res(OP_START, '0, prot_q, 1'b0, '0, ST_BUSY);
          res_o[1]  = mk_res(OP_SEND, dev_d, prot_q, 1'b0, '0, ST_BUSY);
          res_cnt_o = 2'd2;
          ph_d      = PH_R_POLL;
        end
      end
      FN_PAYLOAD: begin
        if (ph_q == PH_W_WANT) begin
          res_o[0]  = mk_res(OP_SEND, item_i.payload_byte, prot_q, 1'b0, '0, ST_BUSY);
          res_cnt_o = 2'd1;
          ph_d      = PH_W_DATA;
        end
      end
      FN_REPLY: begin
        unique case (ph_q)
          PH_W_POLL: begin
            if (item_i.ack_bit) begin
              res_o[0]  = mk_res(OP_START, '0, prot_q, 1'b0, '0, ST_BUSY);
              res_o[1]  = mk_res(OP_SEND, dev_q, prot_q, 1'b0, '0, ST_BUSY);
              res_cnt_o = 2'd2;
            end else begin
              res_o[0]  = mk_res(OP_SEND, cur_q[15:8], prot_q, 1'b0, '0, ST_BUSY);
              res_cnt_o = 2'd1;
              ph_d      = PH_W_ADRH;
            end
          end
          PH_W_ADRH: begin
            res_o[0]  = mk_res(OP_SEND, cur_q[7:0], prot_q, 1'b0, '0, ST_BUSY);
            res_cnt_o = 2'd1;
            ph_d      = PH_W_ADRL;
          end
          PH_W_ADRL: begin
            res_o[0]  = mk_res(OP_NONE, '0, prot_q, 1'b0, '0, ST_WANT);
            res_cnt_o = 2'd1;
            ph_d      = PH_W_WANT;
          end
          PH_W_DATA: begin
            cur_d  = cur_inc;
            done_d = done_inc;
            if (done_inc >= total_q) begin
              // stop goes out before protect is raised
              res_o[0]  = mk_res(OP_STOP, '0, prot_q, 1'b0, '0, ST_BUSY);
              res_o[1]  = mk_res(OP_NONE, '0, 1'b1, 1'b0, '0, ST_DONE);
              res_cnt_o = 2'd2;
              prot_d    = 1'b1;
              ph_d      = PH_IDLE;
            end else if (page_end) begin
              // protect pulse, then a fresh poll with a repeated start
              dev_d     = wdev;
              prot_d    = 1'b0;
              res_o[0]  = mk_res(OP_NONE, '0, 1'b1, 1'b0, '0, ST_BUSY);
              res_o[1]  = mk_res(OP_START, '0, 1'b0, 1'b0, '0, ST_BUSY);
              res_o[2]  = mk_res(OP_SEND, wdev, 1'b0, 1'b0, '0, ST_BUSY);
              res_cnt_o = 2'd3;
              ph_d      = PH_W_POLL;
            end else begin
              res_o[0]  = mk_res(OP_NONE, '0, prot_q, 1'b0, '0, ST_WANT);
              res_cnt_o = 2'd1;
              ph_d      = PH_W_WANT;
            end
          end
          PH_R_POLL: begin
            if (item_i.ack_bit) begin
              poll_d = poll_inc;
              if (poll_inc >= cfg_i.retry) begin
                res_o[0]  = mk_res(OP_NONE, '0, prot_q, 1'b0, '0, ST_FAIL);
                res_cnt_o = 2'd1;
                ph_d      = PH_IDLE;
              end else begin
                res_o[0]  = mk_res(OP_START, '0, prot_q, 1'b0, '0, ST_BUSY);
                res_o[1]  = mk_res(OP_SEND, dev_q, prot_q, 1'b0, '0, ST_BUSY);
                res_cnt_o = 2'd2;
              end
            end else begin
              res_o[0]  = mk_res(OP_SEND, cur_q[15:8], prot_q, 1'b0, '0, ST_BUSY);
              res_cnt_o = 2'd1;
              ph_d      = PH_R_ADRH;
            end
          end
          PH_R_ADRH: begin
            res_o[0]  = mk_res(OP_SEND, cur_q[7:0], prot_q, 1'b0, '0, ST_BUSY);
            res_cnt_o = 2'd1;
            ph_d      = PH_R_ADRL;
          end
          PH_R_ADRL: begin
            res_o[0]  = mk_res(OP_START, '0, prot_q, 1'b0, '0, ST_BUSY);
            res_o[1]  = mk_res(OP_SEND, dev_q | ByteW'(1), prot_q, 1'b0, '0, ST_BUSY);
            res_cnt_o = 2'd2;
            ph_d      = PH_R_DEVRD;
          end
          PH_R_DEVRD: begin
            res_o[0]  = mk_res(OP_RECV, '0, prot_q, 1'b0, '0, ST_BUSY);
            res_cnt_o = 2'd1;
            ph_d      = PH_R_RECV;
          end
          PH_R_RECV: begin
            cur_d  = cur_inc;
            done_d = done_inc;
            if (done_inc >= total_q) begin
              res_o[0]  = mk_res(OP_NOACK, '0, prot_q, 1'b1, item_i.received_byte, ST_BUSY);
              res_o[1]  = mk_res(OP_STOP, '0, prot_q, 1'b0, '0, ST_DONE);
              res_cnt_o = 2'd2;
              ph_d      = PH_IDLE;
            end else begin
              res_o[0]  = mk_res(OP_ACK, '0, prot_q, 1'b1, item_i.received_byte, ST_BUSY);
              res_o[1]  = mk_res(OP_RECV, '0, prot_q, 1'b0, '0, ST_BUSY);
              res_cnt_o = 2'd2;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_IDLE;
      cur_q   <= '0;
      done_q  <= '0;
      total_q <= '0;
      dev_q   <= '0;
      poll_q  <= '0;
      prot_q  <= 1'b1;
    end else if (take_i) begin
      ph_q    <= ph_d;
      cur_q   <= cur_d;
      done_q  <= done_d;
      total_q <= total_d;
      dev_q   <= dev_d;
      poll_q  <= poll_d;
      prot_q  <= prot_d;
    end
  end

endmodule

// ===== hdl/i2c_eeprom_sequential_transfer.sv =====
// timing: a request is registered on acceptance, and its results are registered in
// the result stage before the first one shows
// throughput: one request per cycle while results flow; a request with k results
// (k is at most 3) holds the result stage until all leave while the next one waits
// reset: asynchronous, active low; returns to idle with write protect high and the
// device address registers at their default values
module i2c_eeprom_sequential_transfer #(
  parameter int unsigned PageBytes = i2ces_pkg::PageBytesDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  i2ces_in_if.sink     in_i,
  i2ces_out_if.source  out_o,
  i2ces_cfg_if.sink    cfg_i
);
  import i2ces_pkg::*;

  cfg_t                cfg_q;
  item_t               item_q;
  logic                item_vld_q;
  result_t             res_q [MaxResults];
  result_t             res_new [MaxResults];
  logic [ResCntW-1:0]  cnt_q, cnt_new;
  logic [ResCntW-1:0]  idx_q;
  logic                res_vld_q;
  logic                res_last, out_hs, res_free, take;
  result_t             cur_res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.int_lo <= IntLoRst;
      cfg_q.int_hi <= IntHiRst;
      cfg_q.upd_lo <= UpdLoRst;
      cfg_q.upd_hi <= UpdHiRst;
      cfg_q.flash  <= FlashRst;
      cfg_q.retry  <= RetryRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CfgIntLo: cfg_q.int_lo <= cfg_i.data;
        CfgIntHi: cfg_q.int_hi <= cfg_i.data;
        CfgUpdLo: cfg_q.upd_lo <= cfg_i.data;
        CfgUpdHi: cfg_q.upd_hi <= cfg_i.data;
        CfgFlash: cfg_q.flash  <= cfg_i.data;
        CfgRetry: cfg_q.retry  <= cfg_i.data;
        default: begin
        end
      endcase
    end
  end

  // result stage frees up when its last result leaves in this cycle
  assign cur_res  = res_q[idx_q];
  assign res_last = (idx_q == cnt_q - ResCntW'(1));
  assign out_hs   = res_vld_q && out_o.ready;
  assign res_free = !res_vld_q || (out_o.ready && res_last);
  assign take     = item_vld_q && res_free;
  assign in_i.ready = !item_vld_q || take;

  i2ces_engine #(
    .PageBytes (PageBytes)
  ) u_engine (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .item_i    (item_q),
    .take_i    (take),
    .res_o     (res_new),
    .res_cnt_o (cnt_new)
  );

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      item_q.func          <= func_e'(in_i.func);
      item_q.start_address <= in_i.start_address;
      item_q.byte_count    <= in_i.byte_count;
      item_q.memory_kind   <= in_i.memory_kind;
      item_q.payload_byte  <= in_i.payload_byte;
      item_q.ack_bit       <= in_i.ack_bit;
      item_q.received_byte <= in_i.received_byte;
    end
    if (take && cnt_new != '0) begin
      res_q <= res_new;
      cnt_q <= cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      idx_q      <= '0;
    end else begin
      if (in_i.ready) begin
        item_vld_q <= in_i.valid;
      end
      // a request with no results leaves the result stage alone
      if (take && cnt_new != '0) begin
        res_vld_q <= 1'b1;
        idx_q     <= '0;
      end else if (out_hs) begin
        if (res_last) begin
          res_vld_q <= 1'b0;
        end else begin
          idx_q <= idx_q + ResCntW'(1);
        end
      end
    end
  end

  assign out_o.valid         = res_vld_q;
  assign out_o.bus_op        = cur_res.op;
  assign out_o.tx_byte       = cur_res.tx;
  assign out_o.protect_level = cur_res.prot;
  assign out_o.read_valid    = cur_res.rv;
  assign out_o.read_data     = cur_res.rd;
  assign out_o.status        = cur_res.st;
  assign out_o.last          = res_last;

endmodule

// ===== hdl/i2ces_checker.sv =====
module i2ces_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] bus_op_i,
  input logic [7:0] tx_byte_i,
  input logic       protect_level_i,
  input logic       read_valid_i,
  input logic [1:0] status_i,
  input logic       last_i
);
  import i2ces_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(bus_op_i) && $stable(tx_byte_i)
      && $stable(status_i) && $stable(last_i))
    else $error("result changed while stalled");

  a_rx_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && read_valid_i |-> (bus_op_i == OP_ACK || bus_op_i == OP_NOACK))
    else $error("read data without ack or no-ack");

  a_want: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_WANT |-> bus_op_i == OP_NONE && last_i && !protect_level_i)
    else $error("payload request malformed or write protected");

  a_fail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == ST_FAIL |-> bus_op_i == OP_NONE && last_i)
    else $error("failure report malformed");

endmodule

bind i2c_eeprom_sequential_transfer i2ces_checker u_i2ces_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_o.valid),
  .out_ready_i     (out_o.ready),
  .bus_op_i        (out_o.bus_op),
  .tx_byte_i       (out_o.tx_byte),
  .protect_level_i (out_o.protect_level),
  .read_valid_i    (out_o.read_valid),
  .status_i        (out_o.status),
  .last_i          (out_o.last)
);

// ===== verif/testbench.sv =====
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import i2ces_pkg::*;

  localparam int unsigned PageBytes = PageBytesDef;
  localparam logic [1:0] KindFlash = 2'd2;
  localparam logic [1:0] KindSpare = 2'd3;

  typedef enum logic [3:0] {
    SEQ_IDLE, SEQ_W_POLL, SEQ_W_ADRH, SEQ_W_ADRL, SEQ_W_WANT, SEQ_W_DATA,
    SEQ_R_POLL, SEQ_R_ADRH, SEQ_R_ADRL, SEQ_R_DEVRD, SEQ_R_RECV
  } seq_phase_e;

  typedef struct packed {
    result_t res;
    logic    last;
  } bus_symbol_t;

  logic clk;
  logic rst_n;

  i2ces_in_if  in_ch ();
  i2ces_out_if out_ch ();
  i2ces_cfg_if cfg_ch ();

  i2c_eeprom_sequential_transfer i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  // transfer state mirrored from the block
  seq_phase_e         phase;
  logic [AddrW-1:0]   cur_addr;
  logic [CountW-1:0]  done_cnt;
  logic [CountW-1:0]  total_cnt;
  logic [ByteW-1:0]   dev_byte;
  logic [ByteW-1:0]   polls;
  logic               wp_level;
  cfg_t               regs;

  bus_symbol_t bus_symbols_q[$];

  int  errors;
  int  active_items;
  int  symbols_checked;
  int  writes_seen;
  int  reads_seen;
  int  poll_failures;
  int  reg_writes;
  bit  steady;

  always #6 clk = ~clk;

  function automatic void push_symbol(bus_op_e op, logic [ByteW-1:0] tx, logic rv,
                                      logic [ByteW-1:0] rd, status_e st);
    bus_symbol_t sym;
    sym.res.op   = op;
    sym.res.tx   = tx;
    sym.res.prot = wp_level;
    sym.res.rv   = rv;
    sym.res.rd   = rd;
    sym.res.st   = st;
    sym.last     = 1'b0;
    bus_symbols_q.push_back(sym);
  endfunction

  function automatic void send_device_poll();
    push_symbol(OP_START, 8'h00, 1'b0, 8'h00, ST_BUSY);
    push_symbol(OP_SEND, dev_byte, 1'b0, 8'h00, ST_BUSY);
  endfunction

  function automatic void open_write_poll();
    dev_byte = cur_addr[AddrW-1] ? regs.int_hi : regs.int_lo;
    send_device_poll();
    phase = SEQ_W_POLL;
  endfunction

  // returns the number of bus symbols the request should produce
  function automatic int predict_bus_symbols(item_t it);
    int          queued;
    logic        hi;
    bus_symbol_t tail;
    queued = bus_symbols_q.size();
    if (it.func == FN_WRITE && phase == SEQ_IDLE) begin
      writes_seen++;
      cur_addr  = it.start_address;
      total_cnt = it.byte_count;
      done_cnt  = '0;
      if (it.byte_count == '0) begin
        push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_DONE);
      end else begin
        wp_level = 1'b0;
        open_write_poll();
      end
    end else if (it.func == FN_READ && phase == SEQ_IDLE) begin
      reads_seen++;
      cur_addr  = it.start_address;
      total_cnt = it.byte_count;
      done_cnt  = '0;
      polls     = '0;
      hi        = it.start_address[AddrW-1];
      if (it.memory_kind == KindUpdate) begin
        dev_byte = hi ? regs.upd_hi : regs.upd_lo;
      end else if (it.memory_kind == KindInternal) begin
        dev_byte = hi ? regs.int_hi : regs.int_lo;
      end else begin
        dev_byte = regs.flash;
      end
      send_device_poll();
      phase = SEQ_R_POLL;
    end else if (it.func == FN_PAYLOAD && phase == SEQ_W_WANT) begin
      push_symbol(OP_SEND, it.payload_byte, 1'b0, 8'h00, ST_BUSY);
      phase = SEQ_W_DATA;
    end else if (it.func == FN_REPLY) begin
      case (phase)
        SEQ_W_POLL: begin
          if (it.ack_bit) begin
            send_device_poll();
          end else begin
            push_symbol(OP_SEND, cur_addr[15:8], 1'b0, 8'h00, ST_BUSY);
            phase = SEQ_W_ADRH;
          end
        end
        SEQ_W_ADRH: begin
          push_symbol(OP_SEND, cur_addr[7:0], 1'b0, 8'h00, ST_BUSY);
          phase = SEQ_W_ADRL;
        end
        SEQ_W_ADRL: begin
          push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_WANT);
          phase = SEQ_W_WANT;
        end
        SEQ_W_DATA: begin
          cur_addr = cur_addr + 17'd1;
          done_cnt = done_cnt + 16'd1;
          if (done_cnt >= total_cnt) begin
            push_symbol(OP_STOP, 8'h00, 1'b0, 8'h00, ST_BUSY);
            wp_level = 1'b1;
            push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_DONE);
            phase = SEQ_IDLE;
          end else if (cur_addr % PageBytes == 0) begin
            // page done: pulse write protect, then poll the device again
            wp_level = 1'b1;
            push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_BUSY);
            wp_level = 1'b0;
            open_write_poll();
          end else begin
            push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_WANT);
            phase = SEQ_W_WANT;
          end
        end
        SEQ_R_POLL: begin
          if (it.ack_bit) begin
            polls = polls + 8'd1;
            if (polls >= regs.retry) begin
              push_symbol(OP_NONE, 8'h00, 1'b0, 8'h00, ST_FAIL);
              poll_failures++;
              phase = SEQ_IDLE;
            end else begin
              send_device_poll();
            end
          end else begin
            push_symbol(OP_SEND, cur_addr[15:8], 1'b0, 8'h00, ST_BUSY);
            phase = SEQ_R_ADRH;
          end
        end
        SEQ_R_ADRH: begin
          push_symbol(OP_SEND, cur_addr[7:0], 1'b0, 8'h00, ST_BUSY);
          phase = SEQ_R_ADRL;
        end
        SEQ_R_ADRL: begin
          push_symbol(OP_START, 8'h00, 1'b0, 8'h00, ST_BUSY);
          push_symbol(OP_SEND, dev_byte | 8'h01, 1'b0, 8'h00, ST_BUSY);
          phase = SEQ_R_DEVRD;
        end
        SEQ_R_DEVRD: begin
          push_symbol(OP_RECV, 8'h00, 1'b0, 8'h00, ST_BUSY);
          phase = SEQ_R_RECV;
        end
        SEQ_R_RECV: begin
          cur_addr = cur_addr + 17'd1;
          done_cnt = done_cnt + 16'd1;
          if (done_cnt >= total_cnt) begin
            push_symbol(OP_NOACK, 8'h00, 1'b1, it.received_byte, ST_BUSY);
            push_symbol(OP_STOP, 8'h00, 1'b0, 8'h00, ST_DONE);
            phase = SEQ_IDLE;
          end else begin
            push_symbol(OP_ACK, 8'h00, 1'b1, it.received_byte, ST_BUSY);
            push_symbol(OP_RECV, 8'h00, 1'b0, 8'h00, ST_BUSY);
          end
        end
        default: ;
      endcase
    end
    if (bus_symbols_q.size() > queued) begin
      tail = bus_symbols_q.pop_back();
      tail.last = 1'b1;
      bus_symbols_q.push_back(tail);
    end
    return bus_symbols_q.size() - queued;
  endfunction

  function automatic item_t random_fields();
    item_t it;
    it.func          = func_e'($urandom_range(0, 3));
    it.start_address = AddrW'($urandom);
    it.byte_count    = CountW'($urandom);
    it.memory_kind   = 2'($urandom_range(0, 3));
    it.payload_byte  = ByteW'($urandom);
    it.ack_bit       = 1'($urandom);
    it.received_byte = ByteW'($urandom);
    return it;
  endfunction

  function automatic item_t begin_item(func_e fn, logic [AddrW-1:0] addr,
                                       logic [CountW-1:0] cnt, logic [1:0] kind);
    item_t it;
    it               = random_fields();
    it.func          = fn;
    it.start_address = addr;
    it.byte_count    = cnt;
    it.memory_kind   = kind;
    return it;
  endfunction

  // the request a well-behaved bus and data source would give in the current phase
  function automatic item_t next_in_line(int nack_pct);
    item_t it;
    it = random_fields();
    if (phase == SEQ_W_WANT) begin
      it.func = FN_PAYLOAD;
    end else begin
      it.func = FN_REPLY;
      if (phase == SEQ_W_POLL || phase == SEQ_R_POLL) begin
        it.ack_bit = ($urandom_range(0, 99) < nack_pct);
      end
    end
    return it;
  endfunction

  function automatic void compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      errors++;
    end
  endfunction

  task automatic send_item(item_t it);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 15) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid         = 1'b1;
    in_ch.func          = it.func;
    in_ch.start_address = it.start_address;
    in_ch.byte_count    = it.byte_count;
    in_ch.memory_kind   = it.memory_kind;
    in_ch.payload_byte  = it.payload_byte;
    in_ch.ack_bit       = it.ack_bit;
    in_ch.received_byte = it.received_byte;
    do @(posedge clk); while (!in_ch.ready);
    if (predict_bus_symbols(it) > 0) active_items++;
  endtask

  // hold off new requests until every predicted bus symbol has come out
  task automatic drain_bus_symbols();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (bus_symbols_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
    @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.index = idx;
    cfg_ch.data  = val;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      CfgIntLo: regs.int_lo = val;
      CfgIntHi: regs.int_hi = val;
      CfgUpdLo: regs.upd_lo = val;
      CfgUpdHi: regs.upd_hi = val;
      CfgFlash: regs.flash  = val;
      CfgRetry: regs.retry  = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  task automatic run_until(seq_phase_e stop_at, int poll_nacks);
    int    nacks_left;
    item_t it;
    nacks_left = poll_nacks;
    while (phase != stop_at) begin
      it = next_in_line(0);
      if ((phase == SEQ_W_POLL || phase == SEQ_R_POLL) && nacks_left > 0) begin
        it.ack_bit = 1'b1;
        nacks_left--;
      end
      send_item(it);
    end
  endtask

  task automatic run_random_traffic(int target);
    int               first;
    int unsigned      pick;
    logic [AddrW-1:0] addr;
    logic [CountW-1:0] cnt;
    item_t            it;
    first = active_items;
    while (active_items - first < target || phase != SEQ_IDLE) begin
      if ($urandom_range(0, 99) < 8) begin
        it = random_fields();
        // stray begins that do start a transfer stay short
        if (phase == SEQ_IDLE && (it.func == FN_WRITE || it.func == FN_READ)) begin
          it.byte_count = CountW'(it.byte_count[3:0]);
        end
      end else if (phase == SEQ_IDLE) begin
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          addr = AddrW'($urandom);
        end else if (pick < 85) begin
          addr = {9'($urandom), 8'hf0 + 8'($urandom_range(0, 15))};
        end else begin
          addr = 17'h1fff0 + 17'($urandom_range(0, 15));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
          cnt = '0;
        end else if (pick < 80) begin
          cnt = CountW'($urandom_range(1, 6));
        end else begin
          cnt = CountW'($urandom_range(7, 24));
        end
        it = begin_item($urandom_range(0, 1) ? FN_READ : FN_WRITE, addr, cnt,
                        2'($urandom_range(0, 3)));
      end else begin
        it = next_in_line(30);
      end
      send_item(it);
    end
  endtask

  function automatic logic [ByteW-1:0] pick_device(int round);
    if (round == 0) return 8'd0;
    if (round == 1) return 8'd254;
    return ByteW'($urandom_range(0, 254));
  endfunction

  task automatic test_zero_length();
    send_item(begin_item(FN_WRITE, 17'h1ffff, 16'h0000, KindUpdate));
    send_item(begin_item(FN_READ, 17'h10000, 16'h0000, KindSpare));
    run_until(SEQ_IDLE, 0);
    send_item(begin_item(FN_READ, 17'h00000, 16'h0000, KindUpdate));
    run_until(SEQ_IDLE, 1);
  endtask

  task automatic test_page_wrap_write();
    // wraps from the top address to zero, which also starts a new page
    send_item(begin_item(FN_WRITE, 17'h1ffff, 16'h0003, KindFlash));
    run_until(SEQ_IDLE, 3);
    send_item(begin_item(FN_WRITE, 17'h001fe, 16'h0004, KindInternal));
    run_until(SEQ_IDLE, 0);
  endtask

  task automatic test_out_of_phase();
    item_t it;
    it = random_fields();
    it.func = FN_REPLY;
    send_item(it);
    it.func = FN_PAYLOAD;
    send_item(it);
    send_item(begin_item(FN_READ, 17'h0abcd, 16'h0001, KindInternal));
    it.func = FN_PAYLOAD;
    send_item(it);
    send_item(begin_item(FN_WRITE, 17'h1ffff, 16'hffff, KindUpdate));
    run_until(SEQ_IDLE, 0);
    send_item(begin_item(FN_WRITE, 17'h00100, 16'h0001, KindUpdate));
    run_until(SEQ_W_WANT, 1);
    it.func = FN_REPLY;
    send_item(it);
    run_until(SEQ_IDLE, 0);
  endtask

  task automatic test_read_poll_failure();
    drain_bus_symbols();
    write_register(CfgRetry, 8'd2);
    send_item(begin_item(FN_READ, 17'h12345, 16'h0002, KindFlash));
    run_until(SEQ_IDLE, 2);
  endtask

  task automatic test_register_settings();
    logic [ByteW-1:0] retry;
    for (int round = 0; round < 5; round++) begin
      drain_bus_symbols();
      if (round == 0) begin
        retry = 8'd1;
      end else if (round == 1) begin
        retry = 8'd255;
      end else begin
        retry = $urandom_range(0, 1) ? ByteW'($urandom_range(1, 4))
                                     : ByteW'($urandom_range(5, 255));
      end
      write_register(CfgIntLo, pick_device(round));
      write_register(CfgIntHi, pick_device(round));
      write_register(CfgUpdLo, pick_device(round));
      write_register(CfgUpdHi, pick_device(round));
      write_register(CfgFlash, pick_device(round));
      write_register(CfgRetry, retry);
      run_random_traffic(45);
    end
  endtask

  task automatic test_back_to_back();
    steady = 1'b1;
    run_random_traffic(45);
    steady = 1'b0;
  endtask

  always @(negedge clk) begin
    out_ch.ready = steady || ($urandom_range(0, 99) >= 15);
  end

  always @(posedge clk) begin : check_symbols
    bus_symbol_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (bus_symbols_q.size() == 0) begin
        $error("unexpected bus symbol: bus_op %0d status %0d", out_ch.bus_op, out_ch.status);
        errors++;
      end else begin
        want = bus_symbols_q.pop_front();
        symbols_checked++;
        compare_field("bus_op", want.res.op, out_ch.bus_op);
        compare_field("tx_byte", want.res.tx, out_ch.tx_byte);
        compare_field("protect_level", want.res.prot, out_ch.protect_level);
        compare_field("read_valid", want.res.rv, out_ch.read_valid);
        compare_field("read_data", want.res.rd, out_ch.read_data);
        compare_field("status", want.res.st, out_ch.status);
        compare_field("last", want.last, out_ch.last);
      end
    end
  end

  initial begin
    #3_000_000;
    $display("timeout with %0d bus symbols outstanding", bus_symbols_q.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    steady              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.func          = '0;
    in_ch.start_address = '0;
    in_ch.byte_count    = '0;
    in_ch.memory_kind   = '0;
    in_ch.payload_byte  = '0;
    in_ch.ack_bit       = 1'b0;
    in_ch.received_byte = '0;
    out_ch.ready        = 1'b0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = '0;
    cfg_ch.data         = '0;
    phase               = SEQ_IDLE;
    cur_addr            = '0;
    done_cnt            = '0;
    total_cnt           = '0;
    dev_byte            = '0;
    polls               = '0;
    wp_level            = 1'b1;
    regs.int_lo         = IntLoRst;
    regs.int_hi         = IntHiRst;
    regs.upd_lo         = UpdLoRst;
    regs.upd_hi         = UpdHiRst;
    regs.flash          = FlashRst;
    regs.retry          = RetryRst;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_length();
    test_page_wrap_write();
    test_out_of_phase();
    test_read_poll_failure();
    test_register_settings();
    test_back_to_back();
    drain_bus_symbols();

    $display("covered %0d writes and %0d reads (%0d ended by poll failure), %0d requests",
             writes_seen, reads_seen, poll_failures, active_items);
    $display("checked %0d bus symbols across %0d register writes", symbols_checked,
             reg_writes);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
